// ===== rtl/core/asfc_pkg.sv =====
// ----------------------------------------------------------------------------
// asfc_pkg: shared types and constants for the audio sample format converter
// Holds the payload structs, format codes, register indexes and the
// float/integer conversion helpers.
// ----------------------------------------------------------------------------
package asfc_pkg;

  localparam int unsigned FmtW = 3;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 3;

  localparam logic [FmtW-1:0] FMT_S8 = 3'd0;
  localparam logic [FmtW-1:0] FMT_U8 = 3'd1;
  localparam logic [FmtW-1:0] FMT_S16 = 3'd2;
  localparam logic [FmtW-1:0] FMT_S32 = 3'd3;
  localparam logic [FmtW-1:0] FMT_P24 = 3'd4;
  localparam logic [FmtW-1:0] FMT_F32 = 3'd5;

  localparam logic [CfgIdxW-1:0] REG_SRC_FMT = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_TGT_FMT = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_SRC_SWAP = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_TGT_SWAP = 2'd3;

  localparam logic [31:0] SIGN24 = 32'h0080_0000;
  localparam logic [31:0] HIGH8 = 32'hFF00_0000;
  localparam logic [7:0] OFFS_BIT = 8'h80;

  typedef struct packed {
    logic [31:0] sample_in;
    logic        block_end;
  } in_item_t;

  typedef struct packed {
    logic [31:0] sample_out;
    logic        format_error;
    logic        block_end_out;
  } out_item_t;

  typedef struct packed {
    logic [FmtW-1:0] src_fmt;
    logic [FmtW-1:0] tgt_fmt;
    logic            src_swap;
    logic            tgt_swap;
  } cfg_t;

  // Bytes of a format code: 1, 2 or 4.
  function automatic logic [2:0] fmt_bytes(input logic [FmtW-1:0] f);
    if (f <= FMT_U8) return 3'd1;
    if (f == FMT_S16) return 3'd2;
    return 3'd4;
  endfunction

  function automatic logic [31:0] width_mask(input logic [2:0] n);
    if (n == 3'd1) return 32'h0000_00FF;
    if (n == 3'd2) return 32'h0000_FFFF;
    return 32'hFFFF_FFFF;
  endfunction

  function automatic logic [31:0] swap_bytes(input logic [31:0] v, input logic [2:0] n);
    if (n == 3'd2) return {16'd0, v[7:0], v[15:8]};
    if (n == 3'd4) return {v[7:0], v[15:8], v[23:16], v[31:24]};
    return v;
  endfunction

  // Float times 2^sh (sh = 15 or 23), truncate toward zero, saturate at
  // +/-2^31 (and clip to the target range afterwards by caller). NaN gives 0.
  function automatic logic [31:0] float_to_int(input logic [31:0] x,
                                              input logic [4:0] sh);
    logic [7:0]  e;
    logic [23:0] m;
    logic [8:0]  ue;
    logic [31:0] mag;
    logic        big;
    logic        nan;
    logic [8:0]  shr;
    e = x[30:23];
    m = {1'b1, x[22:0]};
    nan = (e == 8'hFF) && (x[22:0] != 23'd0);
    // value = m * 2^(e - 150 + sh)
    ue = {1'b0, e} + {4'd0, sh};
    big = (ue >= 9'd158);          // |v| >= 2^31
    mag = 32'd0;
    if (e == 8'd0) begin
      mag = 32'd0;
    end else if (ue >= 9'd150) begin
      mag = {8'd0, m} << (ue - 9'd150);
    end else begin
      shr = 9'd150 - ue;
      mag = (shr > 9'd24) ? 32'd0 : ({8'd0, m} >> shr);
    end
    if (nan) return 32'd0;
    if (big) return x[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    return x[31] ? (~mag + 32'd1) : mag;
  endfunction

  // Signed integer (|v| <= 2^31) to float, scaled by 2^-sh, round to nearest even.
  function automatic logic [31:0] int_to_float(input logic [31:0] v,
                                              input logic [4:0] sh);
    logic        s;
    logic [31:0] mag;
    logic [4:0]  lz;
    logic [31:0] nm;
    logic [23:0] mant;
    logic        g;
    logic        st;
    logic [24:0] rm;
    logic [7:0]  ex;
    s = v[31];
    mag = s ? (~v + 32'd1) : v;
    if (mag == 32'd0) return 32'd0;
    lz = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (mag[i]) lz = 5'(31 - i);
    end
    nm = mag << lz;
    mant = nm[31:8];
    g = nm[7];
    st = |nm[6:0];
    rm = {1'b0, mant} + {24'd0, g & (st | mant[0])};
    ex = 8'(8'd158 - {3'd0, lz} - {3'd0, sh});
    if (rm[24]) begin
      ex = ex + 8'd1;
      rm = rm >> 1;
    end
    return {s, ex, rm[22:0]};
  endfunction

endpackage

// ===== rtl/core/audio_sample_format_converter.sv =====
// ----------------------------------------------------------------------------
// audio_sample_format_converter: PCM sample format converter
// Result is valid in the cycle after input accept; one item per cycle unless the output stalls.
// The result register is the only pipeline stage; a full result register
// still accepts a new item when the downstream side takes the old one.
// Reset (async, active low) clears valid and sets s16 -> s16, no swap.
// ----------------------------------------------------------------------------
module audio_sample_format_converter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  asfc_pkg::in_item_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output asfc_pkg::out_item_t           out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [asfc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [asfc_pkg::CfgDataW-1:0] cfg_data_i
);
  import asfc_pkg::*;

  cfg_t      cfg_q;
  out_item_t res_d, res_q;
  logic      valid_q;

  logic [2:0]  sb, tb;
  logic [31:0] x, xs, s16v, y, ym;
  logic [31:0] ext16;
  logic        err, sbyte, tbyte;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o = res_q;

  // Write configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{src_fmt: FMT_S16, tgt_fmt: FMT_S16, src_swap: 1'b0, tgt_swap: 1'b0};
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_SRC_FMT:  cfg_q.src_fmt <= cfg_data_i;
        REG_TGT_FMT:  cfg_q.tgt_fmt <= cfg_data_i;
        REG_SRC_SWAP: cfg_q.src_swap <= cfg_data_i[0];
        REG_TGT_SWAP: cfg_q.tgt_swap <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Convert one item.
  always_comb begin
    sb = fmt_bytes(cfg_q.src_fmt);
    tb = fmt_bytes(cfg_q.tgt_fmt);
    x = in_data_i.sample_in & width_mask(sb);
    xs = cfg_q.src_swap ? swap_bytes(x, sb) : x;
    sbyte = cfg_q.src_fmt <= FMT_U8;
    tbyte = cfg_q.tgt_fmt <= FMT_U8;
    err = 1'b0;
    y = 32'd0;
    if (cfg_q.src_fmt == FMT_F32) begin
      ext16 = float_to_int(xs, 5'd15);
    end else begin
      ext16 = 32'd0;
    end
    // to 16-bit intermediate
    case (cfg_q.src_fmt)
      FMT_S8:  s16v = {16'd0, xs[7:0], 8'd0};
      FMT_U8:  s16v = {16'd0, xs[7:0] ^ OFFS_BIT, 8'd0};
      FMT_F32: s16v = {16'd0, ext16[15:0]};
      FMT_S16: s16v = xs;
      default: s16v = {16'd0, xs[23:8]};
    endcase
    if (cfg_q.src_fmt == FMT_F32) begin
      if ($signed(ext16) > 32'sd32767) s16v = 32'h0000_7FFF;
      else if ($signed(ext16) < -32'sd32768) s16v = 32'h0000_8000;
    end
    if (cfg_q.src_fmt > FMT_F32 || cfg_q.tgt_fmt > FMT_F32) begin
      err = 1'b1;
    end else if (cfg_q.src_fmt == cfg_q.tgt_fmt && cfg_q.src_swap == cfg_q.tgt_swap) begin
      y = x;
    end else if ((sbyte && cfg_q.tgt_fmt != FMT_S16) || (!sbyte && cfg_q.src_fmt != FMT_S16 && tbyte)
                 || (cfg_q.src_fmt == FMT_S16 && cfg_q.tgt_fmt != FMT_S16)) begin
      case (cfg_q.tgt_fmt)
        FMT_S8:  y = {24'd0, s16v[15:8]};
        FMT_U8:  y = {24'd0, s16v[15:8] ^ OFFS_BIT};
        FMT_F32: y = int_to_float({{16{s16v[15]}}, s16v[15:0]}, 5'd15);
        default: y = {{8{s16v[15]}}, s16v[15:0], 8'd0};
      endcase
    end else if (cfg_q.tgt_fmt == FMT_S16) begin
      if (cfg_q.src_fmt == FMT_S16) err = 1'b1;
      else y = {16'd0, s16v[15:0]};
    end else if (cfg_q.src_fmt == FMT_S32 && cfg_q.tgt_fmt == FMT_F32) begin
      y = int_to_float(xs, 5'd23);
    end else if (cfg_q.src_fmt == FMT_F32 && cfg_q.tgt_fmt == FMT_S32) begin
      y = float_to_int(xs, 5'd23);
    end else if (cfg_q.src_fmt == FMT_P24 && cfg_q.tgt_fmt == FMT_F32) begin
      y = int_to_float((xs & 32'h00FF_FFFF) | ((xs & SIGN24) != 0 ? HIGH8 : 32'd0), 5'd23);
    end else if (cfg_q.src_fmt == FMT_F32 && cfg_q.tgt_fmt == FMT_P24) begin
      y = float_to_int(xs, 5'd23);
      if ($signed(y) > 32'sh7F_FFFF) y = 32'h007F_FFFF;
      else if ($signed(y) < -32'sh80_0000) y = 32'hFF80_0000;
    end else begin
      err = 1'b1;
    end
    ym = y & width_mask(tb);
    if (cfg_q.tgt_swap && !(cfg_q.src_fmt == cfg_q.tgt_fmt && cfg_q.src_swap == cfg_q.tgt_swap)) begin
      ym = swap_bytes(ym, tb);
    end
    res_d.sample_out = err ? 32'd0 : ym;
    res_d.format_error = err;
    res_d.block_end_out = in_data_i.block_end;
  end

  // Hold result until taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      res_q <= res_d;
    end
  end

endmodule

// ===== rtl/core/asfc_checker.sv =====
// ----------------------------------------------------------------------------
// asfc_checker: port-level assertions for the format converter
// Checks result timing, stall hold, input readiness and error signaling seen on the ports.
// ----------------------------------------------------------------------------
module asfc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input asfc_pkg::out_item_t out_data_o
);
  import asfc_pkg::*;

  // Flag an error result that carries data.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.format_error |-> out_data_o.sample_out == 32'd0)
    else $error("error item with nonzero sample");

  // Accepted item shows next cycle.
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("result missing after accept");

  // Stalled result holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // Ready whenever output is free.
  a_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("not ready while empty");

endmodule

bind audio_sample_format_converter asfc_checker u_asfc_checker (.*);
